/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`endif

/* rtl/nsem_pkg.sv */
// Types and defaults shared by the semaphore table files.
package nsem_pkg;
	localparam int DefNumSems   = 16;
	localparam int DefQueueDepth = 16;

	typedef enum logic [1:0] {
		REQ_OPEN  = 2'd0,
		REQ_CLOSE = 2'd1,
		REQ_WAIT  = 2'd2,
		REQ_POST  = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_FULL    = 3'd2,
		ST_BLOCKED = 3'd3,
		ST_QFULL   = 3'd4
	} status_t;
endpackage

/* rtl/nsem_if.sv */
// Request and response channel interfaces of the semaphore table.
interface nsem_req_if;
	logic                valid;
	logic                ready;
	nsem_pkg::req_type_t req_type;
	logic [63:0]         name_key;
	logic [7:0]          init_count;
	logic [3:0]          sem_id;
	logic [7:0]          pid;
	modport source (output valid, req_type, name_key, init_count, sem_id, pid,
		input ready);
	modport sink (input valid, req_type, name_key, init_count, sem_id, pid,
		output ready);
endinterface

interface nsem_rsp_if;
	logic              valid;
	logic              ready;
	nsem_pkg::status_t status;
	logic [3:0]        slot_out;
	logic              wake_valid;
	logic [7:0]        wake_pid;
	modport source (output valid, status, slot_out, wake_valid, wake_pid, input ready);
	modport sink (input valid, status, slot_out, wake_valid, wake_pid, output ready);
endinterface

/* rtl/named_counting_semaphore_table.sv */
// Top level of the named counting semaphore table.
// Channel | Dir | Carries
// req     | in  | req_type, name_key, init_count, sem_id, pid
// rsp     | out | status, slot_out, wake_valid, wake_pid
// Open scans the name memory for the key, then bumps the link count of a hit or claims a free slot.
// Close, wait and post read and then write the slot memory; a waking post also reads the waiter queue.
// A request with a bad or unused id skips to the result; each transaction ends in the idle state.
// Reset clears the slot used bits; no clearing pass is needed.
// The result register holds one transaction; a stalled response delays only the next result.
module named_counting_semaphore_table #(
	parameter int NUM_SEMS    = nsem_pkg::DefNumSems,
	parameter int QUEUE_DEPTH = nsem_pkg::DefQueueDepth
) (
	input logic clk,
	input logic arst_n,
	nsem_req_if.sink req,
	nsem_rsp_if.source rsp
);
	import nsem_pkg::*;

	localparam int SW = $clog2(NUM_SEMS);
	localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(NUM_SEMS * QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0]    cnt;
		logic [7:0]    lnk;
		logic [HW-1:0] head;
		logic [FW-1:0] fill;
	} meta_t;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SCAN    = 6'b000010,
		S_META_RD = 6'b000100,
		S_EXEC    = 6'b001000,
		S_WAKE    = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t state_q;

	logic [NUM_SEMS-1:0] used_q;
	logic [63:0] name_mem [NUM_SEMS];
	meta_t       meta_mem [NUM_SEMS];
	logic [7:0]  waiter_mem [NUM_SEMS * QUEUE_DEPTH];

	req_type_t   req_q;
	logic [63:0] key_q;
	logic [7:0]  init_q;
	logic [7:0]  pid_q;
	logic [SW-1:0] tgt_q;
	logic [SW:0]   scan_q;
	logic          cmp_vld_s1;
	logic [SW-1:0] cmp_idx_s1;
	logic [63:0]   name_rd_q;
	logic          free_found_q;
	logic [SW-1:0] free_idx_q;
	meta_t         meta_rd_q;
	logic [7:0]    waiter_rd_q;

	status_t    res_status_q;
	logic [3:0] res_slot_q;
	logic       res_wake_q;
	logic [7:0] res_pid_q;

	logic       out_valid_q;
	status_t    out_status_q;
	logic [3:0] out_slot_q;
	logic       out_wake_q;
	logic [7:0] out_pid_q;

	logic          accept;
	logic [8:0]    id_ext;
	logic          id_ok;
	logic [SW-1:0] id_idx;
	logic          hit;
	logic [8:0]    tgt_ext;
	logic [8:0]    free_ext;

	meta_t         meta_wd;
	logic          meta_we;
	logic          waiter_we;
	logic [AW-1:0] waddr;
	logic [FW:0]   qsum;
	logic [HW-1:0] qpos;
	logic [HW:0]   hinc;
	logic [HW-1:0] hnext;
	status_t       exec_status;
	logic          exec_wake;
	logic          exec_free;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign id_ext   = 9'(req.sem_id);
	assign id_ok    = (id_ext < 9'(NUM_SEMS));
	assign id_idx   = id_ext[SW-1:0];
	assign hit      = cmp_vld_s1 && used_q[cmp_idx_s1] && (name_rd_q == key_q);
	assign tgt_ext  = 9'(tgt_q);
	assign free_ext = 9'(free_idx_q);

	assign qsum  = (FW+1)'(meta_rd_q.head) + (FW+1)'(meta_rd_q.fill);
	assign qpos  = (qsum >= (FW+1)'(QUEUE_DEPTH)) ? HW'(qsum - (FW+1)'(QUEUE_DEPTH))
		: HW'(qsum);
	assign hinc  = (HW+1)'(meta_rd_q.head) + (HW+1)'(1);
	assign hnext = (hinc == (HW+1)'(QUEUE_DEPTH)) ? '0 : HW'(hinc);
	assign waddr = AW'(AW'(tgt_q) * AW'(QUEUE_DEPTH))
		+ AW'((req_q == REQ_WAIT) ? qpos : meta_rd_q.head);

	always_comb begin
		meta_wd     = meta_rd_q;
		meta_we     = 1'b0;
		waiter_we   = 1'b0;
		exec_status = ST_OK;
		exec_wake   = 1'b0;
		exec_free   = 1'b0;
		if (state_q == S_EXEC) begin
			meta_we = 1'b1;
			case (req_q)
				REQ_OPEN: begin
					if (meta_rd_q.lnk != 8'hFF) meta_wd.lnk = meta_rd_q.lnk + 8'd1;
				end
				REQ_CLOSE: begin
					if (meta_rd_q.lnk <= 8'd1) begin
						exec_free    = 1'b1;
						meta_wd.lnk  = 8'd0;
						meta_wd.head = '0;
						meta_wd.fill = '0;
					end else begin
						meta_wd.lnk = meta_rd_q.lnk - 8'd1;
					end
				end
				REQ_WAIT: begin
					if (meta_rd_q.cnt != 8'd0) begin
						meta_wd.cnt = meta_rd_q.cnt - 8'd1;
					end else if (meta_rd_q.fill >= FW'(QUEUE_DEPTH)) begin
						exec_status = ST_QFULL;
					end else begin
						waiter_we    = 1'b1;
						meta_wd.fill = meta_rd_q.fill + FW'(1);
						exec_status  = ST_BLOCKED;
					end
				end
				default: begin
					if (meta_rd_q.cnt != 8'hFF) meta_wd.cnt = meta_rd_q.cnt + 8'd1;
					if (meta_rd_q.fill != '0) begin
						exec_wake    = 1'b1;
						meta_wd.head = hnext;
						meta_wd.fill = meta_rd_q.fill - FW'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && !scan_q[SW] && scan_q < (SW+1)'(NUM_SEMS)) begin
			name_rd_q <= name_mem[scan_q[SW-1:0]];
		end
		if (state_q == S_SCAN && !hit && !(cmp_vld_s1 || scan_q < (SW+1)'(NUM_SEMS))
			&& free_found_q) begin
			name_mem[free_idx_q] <= key_q;
			meta_mem[free_idx_q] <= '{cnt: init_q, lnk: 8'd1, head: '0, fill: '0};
		end
		if (state_q == S_META_RD) meta_rd_q <= meta_mem[tgt_q];
		if (meta_we) meta_mem[tgt_q] <= meta_wd;
		if (waiter_we) waiter_mem[waddr] <= pid_q;
		if (state_q == S_EXEC) waiter_rd_q <= waiter_mem[waddr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req.req_type;
			key_q  <= req.name_key;
			init_q <= req.init_count;
			pid_q  <= req.pid;
			tgt_q  <= id_idx;
			res_status_q <= (req.req_type == REQ_OPEN || (id_ok && used_q[id_idx]))
				? ST_OK : ST_INVALID;
			res_slot_q   <= '0;
			res_wake_q   <= 1'b0;
			res_pid_q    <= '0;
		end
		if (state_q == S_SCAN) begin
			if (cmp_vld_s1 && !used_q[cmp_idx_s1] && !free_found_q) begin
				free_idx_q <= cmp_idx_s1;
			end
			if (scan_q < (SW+1)'(NUM_SEMS)) cmp_idx_s1 <= scan_q[SW-1:0];
			if (hit) begin
				tgt_q <= cmp_idx_s1;
			end else if (!(cmp_vld_s1 || scan_q < (SW+1)'(NUM_SEMS))) begin
				if (free_found_q) res_slot_q <= free_ext[3:0];
				else res_status_q <= ST_FULL;
			end
		end
		if (state_q == S_EXEC) begin
			res_status_q <= exec_status;
			if (req_q == REQ_OPEN) res_slot_q <= tgt_ext[3:0];
		end
		if (state_q == S_WAKE) begin
			res_wake_q <= 1'b1;
			res_pid_q  <= waiter_rd_q;
		end
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_wake_q   <= res_wake_q;
			out_pid_q    <= res_pid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			scan_q       <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q       <= '0;
						cmp_vld_s1   <= 1'b0;
						free_found_q <= 1'b0;
						if (req.req_type == REQ_OPEN) state_q <= S_SCAN;
						else if (id_ok && used_q[id_idx]) state_q <= S_META_RD;
						else state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (cmp_vld_s1 && !used_q[cmp_idx_s1]) free_found_q <= 1'b1;
					if (scan_q < (SW+1)'(NUM_SEMS)) begin
						cmp_vld_s1 <= 1'b1;
						scan_q     <= scan_q + (SW+1)'(1);
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (hit) begin
						state_q <= S_META_RD;
					end else if (!(cmp_vld_s1 || scan_q < (SW+1)'(NUM_SEMS))) begin
						if (free_found_q) used_q[free_idx_q] <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_META_RD: state_q <= S_EXEC;
				S_EXEC: begin
					if (exec_free) used_q[tgt_q] <= 1'b0;
					state_q <= exec_wake ? S_WAKE : S_DONE;
				end
				S_WAKE: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot_out   = out_slot_q;
	assign rsp.wake_valid = out_wake_q;
	assign rsp.wake_pid   = out_pid_q;
endmodule

/* rtl/nsem_checker.sv */
// Port checker for the semaphore table, bound to the top level.
`include "assert_macros.svh"
module nsem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [3:0] slot_out,
	input logic       wake_valid,
	input logic [7:0] wake_pid
);
	import nsem_pkg::*;

	`ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`ASSERT_PROP(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`ASSERT_NEVER(a_wake_only_ok, clk, arst_n, out_valid && wake_valid && status != ST_OK)
	`ASSERT_NEVER(a_pid_zero, clk, arst_n, out_valid && !wake_valid && wake_pid != 8'd0)
	`ASSERT_NEVER(a_slot_zero, clk, arst_n, out_valid && status != ST_OK && slot_out != 4'd0)
endmodule

bind named_counting_semaphore_table nsem_checker u_nsem_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.status(rsp.status),
	.slot_out(rsp.slot_out),
	.wake_valid(rsp.wake_valid),
	.wake_pid(rsp.wake_pid)
);
